FILE: rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stereo peak and rms level meter.
// ----------------------------------------------------------------------------
package spm_pkg;

    // width of the saturating sum of squares, and of the mean taken from it
    localparam int SUM_W = 60;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_START,
        ST_ROOT
    } t_meter_state;

    // divide then square root unit
    typedef enum logic [1:0] {
        ROOT_IDLE,
        ROOT_DIV,
        ROOT_SQRT,
        ROOT_DONE
    } t_root_state;

    // strobes from the sequencer to each channel lane
    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic clear;
    } t_lane_ctrl;

endpackage

FILE: rtl/spm_lane.sv
// ----------------------------------------------------------------------------
// spm_lane
// One channel: magnitude, square, peak hold and saturating sum of squares.
// ----------------------------------------------------------------------------
module spm_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spm_pkg::t_lane_ctrl        i_ctrl,
    input  logic [SAMPLE_BITS-1:0]     i_sample,
    output logic [SAMPLE_BITS-2:0]     o_peak,
    output logic [spm_pkg::SUM_W-1:0]  o_sum
);
    import spm_pkg::*;

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int ADD_W = ((SUM_W > SQ_W) ? SUM_W : SQ_W) + 1;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [SQ_W-1:0]        r_sq;
    logic [SAMPLE_BITS-2:0] r_peak;
    logic [SUM_W-1:0]       r_sum;

    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SAMPLE_BITS-2:0] w_sat_mag;
    logic [ADD_W-1:0]       w_sum_ext;
    logic [SAMPLE_BITS-2:0] n_peak;
    logic [SUM_W-1:0]       n_sum;

    // magnitude of the two's complement sample, full-scale negative included
    assign w_mag = r_sample[SAMPLE_BITS-1] ? (~r_sample + SAMPLE_BITS'(1)) : r_sample;

    // peak candidate, saturated to the largest positive code
    assign w_sat_mag = r_mag[SAMPLE_BITS-1] ? '1 : r_mag[SAMPLE_BITS-2:0];

    // running values
    assign w_sum_ext = ADD_W'(r_sum) + ADD_W'(r_sq);
    assign n_sum     = (|w_sum_ext[ADD_W-1:SUM_W]) ? '1 : w_sum_ext[SUM_W-1:0];
    assign n_peak    = (w_sat_mag > r_peak) ? w_sat_mag : r_peak;

    // sample capture, magnitude and square
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sample <= i_sample;
        end
        if (i_ctrl.square) begin
            r_mag <= w_mag;
            r_sq  <= SQ_W'(w_mag) * SQ_W'(w_mag);
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_sum  <= '0;
        end else if (i_ctrl.clear) begin
            r_peak <= '0;
            r_sum  <= '0;
        end else if (i_ctrl.accum) begin
            r_peak <= n_peak;
            r_sum  <= n_sum;
        end
    end

    assign o_peak = r_peak;
    assign o_sum  = r_sum;

endmodule

FILE: rtl/spm_root.sv
// ----------------------------------------------------------------------------
// spm_root
// Iterative mean and square root: restoring divide one bit a cycle, then a
// digit-by-digit integer square root one result bit a cycle.
// ----------------------------------------------------------------------------
module spm_root #(
    parameter int SAMPLE_BITS = 24,
    parameter int CNT_W       = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_ack,
    input  logic [spm_pkg::SUM_W-1:0]  i_sum,
    input  logic [CNT_W-1:0]           i_count,
    output logic                       o_done,
    output logic [SAMPLE_BITS-2:0]     o_rms
);
    import spm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [SUM_W-1:0] PEAK_MAX = (SUM_W'(1) << (SAMPLE_BITS - 1)) - SUM_W'(1);

    t_root_state r_state;
    t_root_state n_state;

    logic [SUM_W-1:0]  r_x;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_res;
    logic [SUM_W-1:0]  r_bit;
    logic [STEP_W-1:0] r_step;

    logic [CNT_W:0]    w_rem_sh;
    logic              w_rem_ge;
    logic [CNT_W:0]    w_rem_new;
    logic [SUM_W-1:0]  w_trial;
    logic              w_root_ge;

    // divide step
    assign w_rem_sh  = {r_rem, r_x[SUM_W-1]};
    assign w_rem_ge  = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_new = w_rem_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    // square root step
    assign w_trial   = r_res + r_bit;
    assign w_root_ge = (r_x >= w_trial);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ROOT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ROOT_IDLE: begin
                if (i_start) n_state = ROOT_DIV;
            end
            ROOT_DIV: begin
                if (r_step == '0) n_state = ROOT_SQRT;
            end
            ROOT_SQRT: begin
                if (r_step == '0) n_state = ROOT_DONE;
            end
            ROOT_DONE: begin
                if (i_ack) n_state = ROOT_IDLE;
            end
            default: n_state = ROOT_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ROOT_IDLE: begin
                if (i_start) begin
                    r_x    <= i_sum;
                    r_div  <= i_count;
                    r_rem  <= '0;
                    r_step <= STEP_W'(SUM_W - 1);
                end
            end
            ROOT_DIV: begin
                r_rem  <= w_rem_new[CNT_W-1:0];
                r_x    <= {r_x[SUM_W-2:0], w_rem_ge};
                if (r_step == '0) begin
                    r_res  <= '0;
                    r_bit  <= SUM_W'(1) << (SUM_W - 2);
                    r_step <= STEP_W'(SUM_W / 2 - 1);
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
            ROOT_SQRT: begin
                if (w_root_ge) begin
                    r_x   <= r_x - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step - STEP_W'(1);
            end
            ROOT_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == ROOT_DONE);
    assign o_rms  = (r_res > PEAK_MAX) ? '1 : r_res[SAMPLE_BITS-2:0];

endmodule

FILE: rtl/stereo_peak_rms_meter.sv
// ----------------------------------------------------------------------------
// stereo_peak_rms_meter
// Block peak and rms meter for a stereo stream, one lane per channel.
// ----------------------------------------------------------------------------
// Input words carry a left/right sample pair in s_axis_tdata and the end of
// block flag in s_axis_tuser. Each word passes through capture, magnitude
// and square, then accumulation; s_axis_tready is high only in the idle
// state, so a new word is taken only once the last one is through. A word
// that ends a block (flag set, or the count reaching MAX_BLOCK) then starts
// the mean and root unit of both lanes: a restoring divide, then a square
// root, after which the result word is loaded into the output register;
// the next block may start as soon as the result is in the output register.
// The output register holds the result word until m_axis_tready; a new
// result waits in the root unit, with s_axis_tready low, until it is free.
// Reset clears peaks, sums, the sample count and the output valid; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_peak_rms_meter #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_BLOCK   = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // left_sample, right_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // last_of_block
    input  logic                                     s_axis_tuser,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // peak_left, peak_right, rms_left, rms_right
    output logic [((4*(SAMPLE_BITS-1)+7)/8)*8-1:0]   m_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready
);
    import spm_pkg::*;

    localparam int PW    = SAMPLE_BITS - 1;
    localparam int OUT_W = ((4 * PW + 7) / 8) * 8;
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    t_meter_state r_state;
    t_meter_state n_state;
    t_lane_ctrl   w_ctrl;

    logic             r_last;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [PW-1:0]    r_peak_l;
    logic [PW-1:0]    r_peak_r;
    logic             r_out_valid;
    logic [4*PW-1:0]  r_out_data;

    logic             w_accept;
    logic             w_end;
    logic             w_start;
    logic             w_load;

    logic [PW-1:0]    w_peak_l;
    logic [PW-1:0]    w_peak_r;
    logic [SUM_W-1:0] w_sum_l;
    logic [SUM_W-1:0] w_sum_r;
    logic             w_done_l;
    logic             w_done_r;
    logic [PW-1:0]    w_rms_l;
    logic [PW-1:0]    w_rms_r;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign n_count  = r_count + CNT_W'(1);
    assign w_end    = r_last || (n_count == CNT_W'(MAX_BLOCK));
    assign w_load   = (r_state == ST_ROOT) && w_done_l && w_done_r
                      && (!r_out_valid || m_axis_tready);

    // channel lanes
    spm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_peak   (w_peak_l),
        .o_sum    (w_sum_l)
    );

    spm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_sample (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_peak   (w_peak_r),
        .o_sum    (w_sum_r)
    );

    // mean and root per lane
    spm_root #(.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) u_root_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ack   (w_load),
        .i_sum   (w_sum_l),
        .i_count (r_count),
        .o_done  (w_done_l),
        .o_rms   (w_rms_l)
    );

    spm_root #(.SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) u_root_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ack   (w_load),
        .i_sum   (w_sum_r),
        .i_count (r_count),
        .o_done  (w_done_r),
        .o_rms   (w_rms_r)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        w_ctrl        = '0;
        w_start       = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctrl.load   = s_axis_tvalid;
                if (s_axis_tvalid) n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                w_ctrl.square = 1'b1;
                n_state       = ST_ACCUM;
            end
            ST_ACCUM: begin
                w_ctrl.accum = 1'b1;
                n_state      = w_end ? ST_START : ST_IDLE;
            end
            ST_START: begin
                w_start      = 1'b1;
                w_ctrl.clear = 1'b1;
                n_state      = ST_ROOT;
            end
            ST_ROOT: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // flag capture and sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == ST_START) begin
            r_count <= '0;
        end else if (r_state == ST_ACCUM) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= s_axis_tuser;
        end
        if (w_start) begin
            r_peak_l <= w_peak_l;
            r_peak_r <= w_peak_r;
        end
        if (w_load) begin
            r_out_data <= {w_rms_r, w_rms_l, r_peak_r, r_peak_l};
        end
    end

    // merged output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);

endmodule

FILE: rtl/spm_checker.sv
// ----------------------------------------------------------------------------
// spm_checker
// Port level checks on the meter, bound to the top level.
// ----------------------------------------------------------------------------
module spm_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    s_axis_tvalid,
    input logic                                    s_axis_tready,
    input logic [((4*(SAMPLE_BITS-1)+7)/8)*8-1:0]  m_axis_tdata,
    input logic                                    m_axis_tvalid,
    input logic                                    m_axis_tready
);
    localparam int PW = SAMPLE_BITS - 1;

    logic [PW-1:0] w_peak_l;
    logic [PW-1:0] w_peak_r;
    logic [PW-1:0] w_rms_l;
    logic [PW-1:0] w_rms_r;

    assign w_peak_l = m_axis_tdata[PW-1:0];
    assign w_peak_r = m_axis_tdata[2*PW-1:PW];
    assign w_rms_l  = m_axis_tdata[3*PW-1:2*PW];
    assign w_rms_r  = m_axis_tdata[4*PW-1:3*PW];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // rms never exceeds the peak of the same channel
    a_rms_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_rms_l <= w_peak_l) && (w_rms_r <= w_peak_r))
        else $error("rms above peak");

    // an accepted sample word keeps the input side busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a new result is loaded only while the input side is busy
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result word without finished block");

endmodule

bind stereo_peak_rms_meter spm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_spm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
